// ===== sv/assert_macros.svh =====
// Assertion helper macros for the cache block.
// No dependencies; taken in by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cache check failed");
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cache check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sac_pkg.sv =====
// Shared constants and controller/datapath interface types for the cache.
// No dependencies.
`default_nettype none
package sac_pkg;
   localparam int DEF_ADDR_BITS        = 16;
   localparam int DEF_MAX_WAYS         = 8;
   localparam int DEF_MAX_SETS         = 64;
   localparam int DEF_MAX_ACCESS_BYTES = 8;
   localparam int LINE_LOG2_LIMIT      = 6;

   // configuration register indexes
   localparam logic [1:0] REG_LINE_LOG2 = 2'd0;
   localparam logic [1:0] REG_SET_LOG2  = 2'd1;
   localparam logic [1:0] REG_WAYS      = 2'd2;

   // floor of log2, for elaboration-time sizing
   function automatic int floor_log2(input int v);
      int k;
      k = 0;
      while ((k < 30) && ((1 << (k + 1)) <= v)) k++;
      return k;
   endfunction

   typedef struct packed {
      logic load_item;  // latch the word and read its set row
      logic look;       // compare tags, choose way
      logic upd;        // write back the set row
      logic mem_op;     // one byte read or write
      logic done;       // present the result
      logic clr_step;   // clear one memory byte
   } sac_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic byte_last;
      logic no_bytes;
   } sac_sts_type;
endpackage
`default_nettype wire

// ===== sv/sac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== sv/sac_ctrl.sv =====
// Sequencing state machine for the cache: clear, lookup, row update, byte loop.
// Depends on sac_pkg.
`default_nettype none
module sac_ctrl import sac_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   output sac_cmd_type      cmd,
   input  wire sac_sts_type sts
);
   localparam logic [2:0] S_CLR   = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_LOOK  = 3'd2;
   localparam logic [2:0] S_UPD   = 3'd3;
   localparam logic [2:0] S_BYTE  = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load_item = 1'b1;
               state_in      = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.upd  = 1'b1;
            state_in = sts.no_bytes ? S_FIN : S_BYTE;
         end
         S_BYTE: begin
            cmd.mem_op = 1'b1;
            if (sts.byte_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FIN;
         end
         S_FIN: begin
            cmd.done = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

// ===== sv/sac_dp.sv =====
// Cache datapath: set-row store, tag compare, LRU update, byte memory and result.
// Depends on sac_pkg and sac_ram.
`default_nettype none
module sac_dp import sac_pkg::*; #(
   parameter int ADDR_BITS        = DEF_ADDR_BITS,
   parameter int MAX_WAYS         = DEF_MAX_WAYS,
   parameter int MAX_SETS         = DEF_MAX_SETS,
   parameter int MAX_ACCESS_BYTES = DEF_MAX_ACCESS_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sac_cmd_type cmd,
   output sac_sts_type      sts,
   input  wire logic        cfg_clear,
   input  wire logic [2:0]  eff_line_log2,
   input  wire logic [3:0]  eff_set_log2,
   input  wire logic [4:0]  eff_ways,
   input  wire logic        req_command,
   input  wire logic [15:0] req_address,
   input  wire logic [3:0]  req_access_bytes,
   input  wire logic [63:0] req_store_data,
   output logic             rsp_strobe,
   output logic             rsp_was_store,
   output logic             rsp_hit,
   output logic [63:0]      rsp_load_data
);
   localparam int SET_LIM   = floor_log2(MAX_SETS);
   localparam int SET_DEPTH = 1 << SET_LIM;
   localparam int SET_W     = (SET_LIM > 0) ? SET_LIM : 1;
   localparam int RANK_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAY_W     = RANK_W;
   localparam int ENT_W     = 1 + RANK_W + ADDR_BITS;
   localparam int ROW_W     = MAX_WAYS * ENT_W;

   // item registers
   logic                 is_store_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [ADDR_BITS-1:0] tag_ff;
   logic [SET_W-1:0]     set_ff;
   logic [3:0]           nbytes_ff;
   logic [3:0]           cnt_ff;
   logic [63:0]          sdata_ff;
   logic [63:0]          ldata_ff;
   logic                 rd_pend_ff;
   logic [ADDR_BITS-1:0] clr_cnt_ff;
   logic [SET_DEPTH-1:0] rowv_ff;

   // lookup results
   logic             hit_ff;
   logic             touch_ff;
   logic [WAY_W-1:0] way_ff;
   logic [RANK_W-1:0] r_ff;

   // result registers
   logic        rsp_valid_ff;
   logic        rsp_store_ff;
   logic        rsp_hit_ff;
   logic [63:0] rsp_data_ff;

   // address split at accept
   logic [ADDR_BITS-1:0] in_addr;
   logic [ADDR_BITS-1:0] in_tag;
   logic [SET_W-1:0]     in_set;
   logic [SET_W-1:0]     set_mask;
   logic [3:0]           in_nbytes;
   logic [6:0]           pre_shift;

   assign in_addr  = ADDR_BITS'(req_address);
   assign in_tag   = in_addr >> (5'(eff_line_log2) + 5'(eff_set_log2));
   assign set_mask = SET_W'((32'd1 << eff_set_log2) - 32'd1);
   assign in_set   = SET_W'(in_addr >> eff_line_log2) & set_mask;
   assign in_nbytes = (req_access_bytes > 4'(MAX_ACCESS_BYTES)) ?
                      4'(MAX_ACCESS_BYTES) : req_access_bytes;
   assign pre_shift = 7'({3'd0, 4'd8 - in_nbytes} << 3);

   // set-row store
   logic [ROW_W-1:0] row_rd;
   logic [ROW_W-1:0] row_wr;

   sac_ram #(.WIDTH(ROW_W), .DEPTH(SET_DEPTH)) u_row_ram (
      .clock (clock),
      .we    (cmd.upd),
      .waddr (set_ff),
      .wdata (row_wr),
      .re    (cmd.load_item),
      .raddr (in_set),
      .rdata (row_rd)
   );

   // unpack the row; an uncleared row reads as empty
   logic                 row_ok;
   logic [MAX_WAYS-1:0]  vld;
   logic [RANK_W-1:0]    rank [MAX_WAYS];
   logic [ADDR_BITS-1:0] tags [MAX_WAYS];

   assign row_ok = rowv_ff[set_ff];

   always_comb begin
      for (int k = 0; k < MAX_WAYS; k++) begin
         vld[k]  = row_ok && row_rd[k*ENT_W] && (5'(k) < eff_ways);
         rank[k] = row_ok ? row_rd[k*ENT_W+1 +: RANK_W] : '0;
         tags[k] = row_rd[k*ENT_W+1+RANK_W +: ADDR_BITS];
      end
   end

   // hit, free way and LRU victim
   logic              lk_hit;
   logic [WAY_W-1:0]  lk_hway;
   logic              lk_free;
   logic [WAY_W-1:0]  lk_fway;
   logic [WAY_W-1:0]  lk_vway;
   logic [RANK_W-1:0] lk_vrank;
   logic [RANK_W-1:0] lk_count;
   logic [WAY_W-1:0]  lk_way;
   logic [RANK_W-1:0] lk_r;

   always_comb begin
      lk_hit   = 1'b0;
      lk_hway  = '0;
      lk_free  = 1'b0;
      lk_fway  = '0;
      lk_vway  = '0;
      lk_vrank = '0;
      for (int k = 0; k < MAX_WAYS; k++) begin
         if (vld[k] && (tags[k] == tag_ff) && !lk_hit) begin
            lk_hit  = 1'b1;
            lk_hway = WAY_W'(k);
         end
         if ((5'(k) < eff_ways) && !vld[k] && !lk_free) begin
            lk_free = 1'b1;
            lk_fway = WAY_W'(k);
         end
         if ((5'(k) < eff_ways) && (rank[k] >= lk_vrank)) begin
            lk_vrank = rank[k];
            lk_vway  = WAY_W'(k);
         end
      end
      lk_count = RANK_W'($countones(vld));
      if (lk_hit) begin
         lk_way = lk_hway;
         lk_r   = rank[lk_hway];
      end else if (lk_free) begin
         lk_way = lk_fway;
         lk_r   = lk_count;
      end else begin
         lk_way = lk_vway;
         lk_r   = lk_vrank;
      end
   end

   // new row: age younger valid ways, make the chosen way most recent
   always_comb begin
      logic                 nv;
      logic [RANK_W-1:0]    nr;
      logic [ADDR_BITS-1:0] nt;
      row_wr = '0;
      for (int k = 0; k < MAX_WAYS; k++) begin
         nv = vld[k];
         nr = rank[k];
         nt = tags[k];
         if (touch_ff && (5'(k) < eff_ways)) begin
            if (WAY_W'(k) == way_ff) begin
               nr = '0;
               if (!hit_ff) begin
                  nv = 1'b1;
                  nt = tag_ff;
               end
            end else if (vld[k] && (rank[k] < r_ff)) begin
               nr = rank[k] + 1'b1;
            end
         end
         row_wr[k*ENT_W +: ENT_W] = {nt, nr, nv};
      end
   end

   // byte memory
   logic [7:0]           mem_rd;
   logic [ADDR_BITS-1:0] mem_waddr;

   assign mem_waddr = cmd.clr_step ? clr_cnt_ff : addr_ff;

   sac_ram #(.WIDTH(8), .DEPTH(1 << ADDR_BITS)) u_mem_ram (
      .clock (clock),
      .we    (cmd.clr_step || (cmd.mem_op && is_store_ff)),
      .waddr (mem_waddr),
      .wdata (cmd.clr_step ? 8'd0 : sdata_ff[63:56]),
      .re    (cmd.mem_op && !is_store_ff),
      .raddr (addr_ff),
      .rdata (mem_rd)
   );

   // latch item, lookup, byte loop
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         is_store_ff <= req_command;
         addr_ff     <= in_addr;
         tag_ff      <= in_tag;
         set_ff      <= in_set;
         nbytes_ff   <= in_nbytes;
         cnt_ff      <= '0;
         sdata_ff    <= req_store_data << pre_shift;
         ldata_ff    <= '0;
      end else if (cmd.mem_op) begin
         addr_ff  <= addr_ff + 1'b1;
         cnt_ff   <= cnt_ff + 1'b1;
         sdata_ff <= sdata_ff << 8;
      end
      if (rd_pend_ff) begin
         ldata_ff <= {ldata_ff[55:0], mem_rd};
      end
      if (cmd.look) begin
         hit_ff   <= lk_hit;
         touch_ff <= lk_hit || !is_store_ff;
         way_ff   <= lk_way;
         r_ff     <= lk_r;
      end
      if (cmd.done) begin
         rsp_store_ff <= is_store_ff;
         rsp_hit_ff   <= hit_ff;
         rsp_data_ff  <= is_store_ff ? 64'd0 : ldata_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         rowv_ff      <= '0;
      end else begin
         rd_pend_ff   <= cmd.mem_op && !is_store_ff;
         rsp_valid_ff <= cmd.done;
         if (cmd.clr_step) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (cfg_clear) begin
            rowv_ff <= '0;
         end else if (cmd.upd) begin
            rowv_ff[set_ff] <= 1'b1;
         end
      end
   end

   assign sts.clr_last  = &clr_cnt_ff;
   assign sts.byte_last = (cnt_ff == nbytes_ff - 1'b1);
   assign sts.no_bytes  = (nbytes_ff == 4'd0);

   assign rsp_strobe    = rsp_valid_ff;
   assign rsp_was_store = rsp_store_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_load_data = rsp_data_ff;
endmodule
`default_nettype wire

// ===== sv/set_assoc_lru_write_through_cache.sv =====
// Top level of the set-associative write-through cache: registers, FSM, datapath.
// Depends on sac_pkg, sac_ctrl, sac_dp and assert_macros.svh.
//
// Usage: drive req_* and raise start; the word is taken on an edge where start
// is high and busy is low. One result word follows per access on rsp_*, marked
// by rsp_strobe for exactly one cycle; the receiver cannot stall it.
// Busy drops in the strobe cycle, so a new access can be taken once the result
// of the last one shows, not before. The byte loop runs over the byte memory
// one byte per cycle; the tag/LRU row is read and written back once per access.
// Reset: registers return to line 16 bytes, 16 sets, 2 ways, all lines
// invalid; the backing memory is then zeroed, one byte per cycle, all
// 2^ADDR_BITS bytes, with busy high. Configuration writes over the APB port
// (psel/penable/pwrite, pready always high) are taken at any time, but only
// while idle by contract; each one to a defined register invalidates all
// lines. Memory contents are kept.
`default_nettype none
`include "assert_macros.svh"
module set_assoc_lru_write_through_cache import sac_pkg::*; #(
   parameter int ADDR_BITS        = DEF_ADDR_BITS,
   parameter int MAX_WAYS         = DEF_MAX_WAYS,
   parameter int MAX_SETS         = DEF_MAX_SETS,
   parameter int MAX_ACCESS_BYTES = DEF_MAX_ACCESS_BYTES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_command,
   input  wire logic [15:0] req_address,
   input  wire logic [3:0]  req_access_bytes,
   input  wire logic [63:0] req_store_data,
   output logic             rsp_strobe,
   output logic             rsp_was_store,
   output logic             rsp_hit,
   output logic [63:0]      rsp_load_data,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   localparam int SET_LIM = floor_log2(MAX_SETS);

   logic [2:0] line_log2_ff;
   logic [2:0] set_log2_ff;
   logic [3:0] ways_ff;
   logic       cfg_wr;
   logic       cfg_clear;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   // register writes; any defined register flushes the lines
   always_ff @(posedge clock) begin
      if (reset) begin
         line_log2_ff <= 3'd4;
         set_log2_ff  <= 3'd4;
         ways_ff      <= 4'd2;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_LINE_LOG2: line_log2_ff <= pwdata[2:0];
            REG_SET_LOG2:  set_log2_ff  <= pwdata[2:0];
            REG_WAYS:      ways_ff      <= pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg_clear = cfg_wr && ((reg_idx == REG_LINE_LOG2) || (reg_idx == REG_SET_LOG2) ||
                                 (reg_idx == REG_WAYS));

   // register reads
   always_comb begin
      unique case (reg_idx)
         REG_LINE_LOG2: prdata = {29'd0, line_log2_ff};
         REG_SET_LOG2:  prdata = {29'd0, set_log2_ff};
         REG_WAYS:      prdata = {28'd0, ways_ff};
         default:       prdata = 32'd0;
      endcase
   end

   // clamp configuration to the built limits
   logic [2:0] eff_line_log2;
   logic [3:0] eff_set_log2;
   logic [4:0] eff_ways;

   assign eff_line_log2 = (line_log2_ff > 3'(LINE_LOG2_LIMIT)) ?
                          3'(LINE_LOG2_LIMIT) : line_log2_ff;
   assign eff_set_log2  = ({1'b0, set_log2_ff} > 4'(SET_LIM)) ?
                          4'(SET_LIM) : {1'b0, set_log2_ff};
   assign eff_ways = (ways_ff == 4'd0) ? 5'd1 :
                     (({1'b0, ways_ff} > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : {1'b0, ways_ff});

   sac_cmd_type cmd;
   sac_sts_type sts;

   sac_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   sac_dp #(
      .ADDR_BITS        (ADDR_BITS),
      .MAX_WAYS         (MAX_WAYS),
      .MAX_SETS         (MAX_SETS),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg_clear        (cfg_clear),
      .eff_line_log2    (eff_line_log2),
      .eff_set_log2     (eff_set_log2),
      .eff_ways         (eff_ways),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_access_bytes (req_access_bytes),
      .req_store_data   (req_store_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_was_store    (rsp_was_store),
      .rsp_hit          (rsp_hit),
      .rsp_load_data    (rsp_load_data)
   );

   // an accepted word keeps the block busy until its result
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the result strobe is a single-cycle pulse
   `ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)
   // the result shows only once the block is free again
   `ASSERT_IMPLY(a_strobe_idle, clock, reset, rsp_strobe, !busy)
   // stores return no load data
   `ASSERT_IMPLY(a_store_zero, clock, reset, rsp_strobe && rsp_was_store,
                 rsp_load_data == 64'd0)
endmodule
`default_nettype wire
